// File: src/fixed_timestep_tick_scheduler_defines.svh
// -----------------------------------------------------------------------------
// Fixed-timestep tick scheduler: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef FIXED_TIMESTEP_TICK_SCHEDULER_DEFINES_SVH
`define FIXED_TIMESTEP_TICK_SCHEDULER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FTTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FTTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ftts_pkg.sv
// -----------------------------------------------------------------------------
// Fixed-timestep tick scheduler package
// Field widths, register indexes, reset values, FSM state and datapath ops.
// -----------------------------------------------------------------------------
package ftts_pkg;

	localparam int NS_W      = 30;	// holds 1e9 and any tick span
	localparam int RATE_W    = 10;
	localparam int STEP_W    = 6;
	localparam int DT_W      = 32;
	localparam int ELAPSED_W = 64;
	localparam int FRAME_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

	localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = 2'd2;

	localparam logic [RATE_W-1:0] TICK_RATE_RST = 10'd60;
	localparam logic [DT_W-1:0]   MAX_FRAME_RST = 32'd250000000;
	localparam logic [STEP_W-1:0] MAX_STEPS_RST = 6'd15;

	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RATE_DIV,
		S_SCAN_INIT,
		S_SCAN,
		S_SEED,
		S_CHECK,
		S_BLEND_INIT,
		S_BLEND_DIV,
		S_SUMMARY
	} state_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_DIV_STEP,
		OP_SCAN_START,
		OP_SCAN_STEP,
		OP_SEED,
		OP_TICK,
		OP_PREP,
		OP_BLEND_START,
		OP_SUMMARY
	} op_t;

	typedef struct packed {
		logic stale;		// boundary registers need a rebuild
		logic fire;			// next boundary reached and step cap not hit
		logic cnt_zero;		// shared step counter at its last step
		logic slot_free;	// output register can take a new item
	} dp_status_t;

endpackage

// File: src/ftts_ctrl.sv
// -----------------------------------------------------------------------------
// Fixed-timestep tick scheduler: controller
// Sequences the per-frame work and issues one datapath op per cycle.
// -----------------------------------------------------------------------------
module ftts_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  ftts_pkg::dp_status_t   status,
	output ftts_pkg::op_t          op
);

	ftts_pkg::state_t state_q;
	ftts_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftts_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op      = ftts_pkg::OP_NOP;
		case (state_q)
			ftts_pkg::S_IDLE: begin
				if (in_valid) begin
					op      = ftts_pkg::OP_ACCEPT;
					state_d = status.stale ? ftts_pkg::S_RATE_DIV : ftts_pkg::S_CHECK;
				end
			end
			ftts_pkg::S_RATE_DIV: begin
				op = ftts_pkg::OP_DIV_STEP;
				if (status.cnt_zero) begin
					state_d = ftts_pkg::S_SCAN_INIT;
				end
			end
			ftts_pkg::S_SCAN_INIT: begin
				op      = ftts_pkg::OP_SCAN_START;
				state_d = ftts_pkg::S_SCAN;
			end
			ftts_pkg::S_SCAN: begin
				op = ftts_pkg::OP_SCAN_STEP;
				if (status.cnt_zero) begin
					state_d = ftts_pkg::S_SEED;
				end
			end
			ftts_pkg::S_SEED: begin
				op      = ftts_pkg::OP_SEED;
				state_d = ftts_pkg::S_CHECK;
			end
			ftts_pkg::S_CHECK: begin
				if (status.fire) begin
					if (status.slot_free) begin
						op = ftts_pkg::OP_TICK;
					end
				end else begin
					op      = ftts_pkg::OP_PREP;
					state_d = ftts_pkg::S_BLEND_INIT;
				end
			end
			ftts_pkg::S_BLEND_INIT: begin
				op      = ftts_pkg::OP_BLEND_START;
				state_d = ftts_pkg::S_BLEND_DIV;
			end
			ftts_pkg::S_BLEND_DIV: begin
				op = ftts_pkg::OP_DIV_STEP;
				if (status.cnt_zero) begin
					state_d = ftts_pkg::S_SUMMARY;
				end
			end
			ftts_pkg::S_SUMMARY: begin
				if (status.slot_free) begin
					op      = ftts_pkg::OP_SUMMARY;
					state_d = ftts_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ftts_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ftts_pkg::S_IDLE);

endmodule

// File: src/ftts_dp.sv
// -----------------------------------------------------------------------------
// Fixed-timestep tick scheduler: datapath
// Config registers, time state, incremental tick boundaries, shared
// bit-per-cycle divider, bit-serial boundary rebuild and output register.
// -----------------------------------------------------------------------------
`include "fixed_timestep_tick_scheduler_defines.svh"

module ftts_dp #(
	parameter int FRACTION_BITS = 16,
	parameter int TICK_BITS     = 36
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ftts_pkg::op_t                     op,
	output ftts_pkg::dp_status_t              status,
	input  logic                              cfg_wr_en,
	input  logic [ftts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ftts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [ftts_pkg::DT_W-1:0]         frame_dur,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic                              kind,
	output logic [TICK_BITS-1:0]              tick_index,
	output logic [ftts_pkg::STEP_W-1:0]       steps_run,
	output logic                              was_clamped,
	output logic [FRACTION_BITS-1:0]          blend_fraction,
	output logic [ftts_pkg::FRAME_W-1:0]      frame_number,
	output logic                              last
);

	localparam int NS_W   = ftts_pkg::NS_W;
	localparam int RATE_W = ftts_pkg::RATE_W;
	localparam int EL_W   = ftts_pkg::ELAPSED_W;
	localparam int BND_W  = TICK_BITS + NS_W;
	localparam int CMP_W  = (BND_W > EL_W) ? BND_W : EL_W;
	localparam int QW     = (FRACTION_BITS > NS_W) ? FRACTION_BITS : NS_W;
	localparam int CNT_N0 = (TICK_BITS > NS_W) ? TICK_BITS : NS_W;
	localparam int CNT_N  = (FRACTION_BITS > CNT_N0) ? FRACTION_BITS : CNT_N0;
	localparam int CNT_W  = $clog2(CNT_N);
	localparam int TIDX_W = $clog2(TICK_BITS);

	// control state
	logic [RATE_W-1:0]                rate_q;
	logic [ftts_pkg::DT_W-1:0]        max_frame_q;
	logic [ftts_pkg::STEP_W-1:0]      max_steps_q;
	logic                             stale_q;
	logic [EL_W-1:0]                  elapsed_q;
	logic [TICK_BITS-1:0]             tick_q;
	logic [ftts_pkg::FRAME_W-1:0]     frame_q;
	logic                             out_valid_q;

	// working registers
	logic [ftts_pkg::STEP_W-1:0]      steps_q;
	logic                             clamped_q;
	logic [NS_W-1:0]                  q0_q;
	logic [RATE_W-1:0]                r0_q;
	logic [BND_W-1:0]                 cur_bnd_q;
	logic [RATE_W-1:0]                cur_rem_q;
	logic [BND_W-1:0]                 nxt_bnd_q;
	logic [RATE_W-1:0]                nxt_rem_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [NS_W-1:0]                  rem_q;
	logic [NS_W-1:0]                  dvs_q;
	logic [NS_W-1:0]                  dvd_q;
	logic [QW-1:0]                    quot_q;
	logic                             blend_zero_q;
	logic [NS_W-1:0]                  span_q;
	logic [EL_W-1:0]                  into_q;

	// output register
	logic                             kind_q;
	logic [TICK_BITS-1:0]             tick_index_q;
	logic [ftts_pkg::STEP_W-1:0]      steps_run_q;
	logic                             was_clamped_q;
	logic [FRACTION_BITS-1:0]         blend_fraction_q;
	logic [ftts_pkg::FRAME_W-1:0]     frame_number_q;
	logic                             last_q;

	logic [RATE_W-1:0]                eff_rate;
	logic                             dt_over;
	logic [ftts_pkg::DT_W-1:0]        dt_eff;
	logic [TICK_BITS-1:0]             tick_inc;
	logic [CMP_W-1:0]                 el_ext;
	logic [CMP_W-1:0]                 cur_ext;
	logic [CMP_W-1:0]                 nxt_ext;
	logic                             fire;

	// divider
	logic [NS_W:0]                    div_trial;
	logic [NS_W:0]                    div_diff;
	logic                             div_ge;
	logic [NS_W-1:0]                  rem_nxt;

	// bit-serial rebuild of floor(t*1e9/rate)
	logic                             scan_bit;
	logic [RATE_W+1:0]                scan_r2;
	logic [RATE_W+1:0]                rate_x1;
	logic [RATE_W+1:0]                rate_x2;
	logic [RATE_W+1:0]                scan_rem_w;
	logic [1:0]                       scan_c;
	logic [BND_W-1:0]                 scan_bnd;

	// one-tick boundary increment
	logic [BND_W-1:0]                 inc_src_bnd;
	logic [RATE_W-1:0]                inc_src_rem;
	logic [RATE_W:0]                  inc_sum;
	logic [RATE_W:0]                  inc_sub;
	logic                             inc_carry;
	logic [RATE_W-1:0]                inc_rem;
	logic [BND_W-1:0]                 inc_bnd;
	logic                             inc_wrap;

	// fraction setup
	logic [BND_W-1:0]                 bnd_diff;
	logic [CMP_W-1:0]                 into_full;
	logic                             into_ge;
	logic [NS_W-1:0]                  span_m1;

	assign eff_rate = (rate_q == '0) ? RATE_W'(1) : rate_q;
	assign dt_over  = frame_dur > max_frame_q;
	assign dt_eff   = dt_over ? max_frame_q : frame_dur;
	assign tick_inc = tick_q + 1'b1;

	assign el_ext  = CMP_W'(elapsed_q);
	assign cur_ext = CMP_W'(cur_bnd_q);
	assign nxt_ext = CMP_W'(nxt_bnd_q);
	assign fire    = (nxt_ext <= el_ext) && (steps_q < max_steps_q);

	// restoring division, one quotient bit per step
	assign div_trial = {rem_q, dvd_q[NS_W-1]};
	assign div_ge    = div_trial >= {1'b0, dvs_q};
	assign div_diff  = div_trial - {1'b0, dvs_q};
	assign rem_nxt   = div_ge ? div_diff[NS_W-1:0] : div_trial[NS_W-1:0];

	// prefix p -> 2p+b: quotient doubles plus b*Q0, remainder 2r+b*R0 folded
	// back below rate with at most two subtractions
	assign scan_bit = tick_q[cnt_q[TIDX_W-1:0]];
	assign scan_r2  = {1'b0, cur_rem_q, 1'b0} + (scan_bit ? {2'b00, r0_q} : '0);
	assign rate_x1  = {2'b00, eff_rate};
	assign rate_x2  = {1'b0, eff_rate, 1'b0};

	always_comb begin
		if (scan_r2 >= rate_x2) begin
			scan_c     = 2'd2;
			scan_rem_w = scan_r2 - rate_x2;
		end else if (scan_r2 >= rate_x1) begin
			scan_c     = 2'd1;
			scan_rem_w = scan_r2 - rate_x1;
		end else begin
			scan_c     = 2'd0;
			scan_rem_w = scan_r2;
		end
	end

	assign scan_bnd = {cur_bnd_q[BND_W-2:0], 1'b0} + (scan_bit ? BND_W'(q0_q) : '0)
		+ BND_W'(scan_c);

	// B(t+1) = B(t) + Q0 + carry of the remainder
	assign inc_src_bnd = (op == ftts_pkg::OP_SEED) ? cur_bnd_q : nxt_bnd_q;
	assign inc_src_rem = (op == ftts_pkg::OP_SEED) ? cur_rem_q : nxt_rem_q;
	assign inc_sum     = {1'b0, inc_src_rem} + {1'b0, r0_q};
	assign inc_carry   = inc_sum >= {1'b0, eff_rate};
	assign inc_sub     = inc_sum - {1'b0, eff_rate};
	assign inc_rem     = inc_carry ? inc_sub[RATE_W-1:0] : inc_sum[RATE_W-1:0];
	assign inc_bnd     = inc_src_bnd + BND_W'(q0_q) + BND_W'(inc_carry);
	// tick count wrap: the boundary after the last count restarts at zero
	assign inc_wrap    = (op == ftts_pkg::OP_SEED) ? (&tick_q) : (&tick_inc);

	assign bnd_diff  = nxt_bnd_q - cur_bnd_q;
	assign into_full = el_ext - cur_ext;
	assign into_ge   = into_q >= EL_W'(span_q);
	assign span_m1   = span_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= ftts_pkg::TICK_RATE_RST;
			max_frame_q <= ftts_pkg::MAX_FRAME_RST;
			max_steps_q <= ftts_pkg::MAX_STEPS_RST;
			stale_q     <= 1'b1;
			elapsed_q   <= '0;
			tick_q      <= '0;
			frame_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (op)
				ftts_pkg::OP_ACCEPT: begin
					elapsed_q <= elapsed_q + EL_W'(dt_eff);
				end
				ftts_pkg::OP_SEED: begin
					stale_q <= 1'b0;
				end
				ftts_pkg::OP_TICK: begin
					tick_q      <= tick_inc;
					out_valid_q <= 1'b1;
				end
				ftts_pkg::OP_SUMMARY: begin
					frame_q     <= frame_q + 1'b1;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
			if (cfg_wr_en) begin
				case (cfg_index)
					ftts_pkg::REG_TICK_RATE: begin
						rate_q  <= cfg_data[RATE_W-1:0];
						stale_q <= 1'b1;
					end
					ftts_pkg::REG_MAX_FRAME: begin
						max_frame_q <= cfg_data[ftts_pkg::DT_W-1:0];
					end
					ftts_pkg::REG_MAX_STEPS: begin
						max_steps_q <= cfg_data[ftts_pkg::STEP_W-1:0];
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			ftts_pkg::OP_ACCEPT: begin
				steps_q   <= '0;
				clamped_q <= dt_over;
				// set up 1e9 / rate in case the boundaries need a rebuild
				rem_q     <= '0;
				dvs_q     <= NS_W'(eff_rate);
				dvd_q     <= ftts_pkg::NS_PER_SEC;
				cnt_q     <= CNT_W'(NS_W - 1);
			end
			ftts_pkg::OP_DIV_STEP: begin
				rem_q  <= rem_nxt;
				dvd_q  <= {dvd_q[NS_W-2:0], 1'b0};
				quot_q <= {quot_q[QW-2:0], div_ge};
				cnt_q  <= cnt_q - 1'b1;
			end
			ftts_pkg::OP_SCAN_START: begin
				q0_q      <= quot_q[NS_W-1:0];
				r0_q      <= rem_q[RATE_W-1:0];
				cur_bnd_q <= '0;
				cur_rem_q <= '0;
				cnt_q     <= CNT_W'(TICK_BITS - 1);
			end
			ftts_pkg::OP_SCAN_STEP: begin
				cur_bnd_q <= scan_bnd;
				cur_rem_q <= scan_rem_w[RATE_W-1:0];
				cnt_q     <= cnt_q - 1'b1;
			end
			ftts_pkg::OP_SEED: begin
				nxt_bnd_q <= inc_wrap ? '0 : inc_bnd;
				nxt_rem_q <= inc_wrap ? '0 : inc_rem;
			end
			ftts_pkg::OP_TICK: begin
				cur_bnd_q        <= nxt_bnd_q;
				cur_rem_q        <= nxt_rem_q;
				nxt_bnd_q        <= inc_wrap ? '0 : inc_bnd;
				nxt_rem_q        <= inc_wrap ? '0 : inc_rem;
				steps_q          <= steps_q + 1'b1;
				kind_q           <= ftts_pkg::KIND_TICK;
				tick_index_q     <= tick_q;
				steps_run_q      <= '0;
				was_clamped_q    <= 1'b0;
				blend_fraction_q <= '0;
				frame_number_q   <= frame_q;
				last_q           <= 1'b0;
			end
			ftts_pkg::OP_PREP: begin
				// zero fraction when elapsed is short of B(t) or the span is empty
				blend_zero_q <= (cur_ext > el_ext) || (nxt_bnd_q <= cur_bnd_q);
				span_q       <= bnd_diff[NS_W-1:0];
				into_q       <= into_full[EL_W-1:0];
			end
			ftts_pkg::OP_BLEND_START: begin
				rem_q <= into_ge ? span_m1 : into_q[NS_W-1:0];
				dvs_q <= span_q;
				dvd_q <= '0;
				cnt_q <= CNT_W'(FRACTION_BITS - 1);
			end
			ftts_pkg::OP_SUMMARY: begin
				kind_q           <= ftts_pkg::KIND_SUMMARY;
				tick_index_q     <= tick_q;
				steps_run_q      <= steps_q;
				was_clamped_q    <= clamped_q;
				blend_fraction_q <= blend_zero_q ? '0 : quot_q[FRACTION_BITS-1:0];
				frame_number_q   <= frame_q;
				last_q           <= 1'b1;
			end
			default: ;
		endcase
	end

	assign status.stale     = stale_q;
	assign status.fire      = fire;
	assign status.cnt_zero  = (cnt_q == '0);
	assign status.slot_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign tick_index     = tick_index_q;
	assign steps_run      = steps_run_q;
	assign was_clamped    = was_clamped_q;
	assign blend_fraction = blend_fraction_q;
	assign frame_number   = frame_number_q;
	assign last           = last_q;

	`FTTS_ASSERT_NOW(a_rem_below_rate, !stale_q, (cur_rem_q < eff_rate) && (nxt_rem_q < eff_rate), "boundary remainder not below rate")
	`FTTS_ASSERT_NEXT(a_tick_counts_step, op == ftts_pkg::OP_TICK, steps_q == $past(steps_q) + 1'b1, "fired tick did not count a step")
	`FTTS_ASSERT_NEXT(a_summary_closes_frame, op == ftts_pkg::OP_SUMMARY, out_valid_q && last_q && (frame_q == $past(frame_q) + 1'b1), "summary did not close the frame")

endmodule

// File: src/fixed_timestep_tick_scheduler.sv
// -----------------------------------------------------------------------------
// Fixed-timestep tick scheduler
// Takes one frame duration per item, clamps it, adds it to elapsed time and
// fires whole ticks up to a step cap, then closes the frame with a summary
// carrying the step count, clamp flag, frame number and 0.N blend fraction.
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_stall    frame_dur
//   out      out  out_valid / out_stall  kind, tick_index, steps_run,
//                                        was_clamped, blend_fraction,
//                                        frame_number, last
//   cfg      in   cfg_wr_en              cfg_index, cfg_data
//
// Per frame, from accept to the next accept: each fired tick is one
// incremental boundary update, then the fraction is set up and found on the
// bit-per-cycle divider before the summary is loaded.
// After reset or a tick_rate_hz write the first frame also computes
// 1e9/rate on the same divider, then runs a bit-serial boundary rebuild.
// in_stall is high from accept until the summary is loaded; the summary may
// wait in the output register while the next item is accepted.
// out_stall holds the current item; tick firing pauses until it is taken.
// -----------------------------------------------------------------------------
module fixed_timestep_tick_scheduler #(
	parameter int FRACTION_BITS = 16,
	parameter int TICK_BITS     = 36
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [ftts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ftts_pkg::CFG_DATA_W-1:0]   cfg_data,
	// frame items in
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ftts_pkg::DT_W-1:0]         frame_dur,
	// tick and summary items out
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              kind,
	output logic [TICK_BITS-1:0]              tick_index,
	output logic [ftts_pkg::STEP_W-1:0]       steps_run,
	output logic                              was_clamped,
	output logic [FRACTION_BITS-1:0]          blend_fraction,
	output logic [ftts_pkg::FRAME_W-1:0]      frame_number,
	output logic                              last
);

	// one op per cycle from the controller, status back from the datapath
	ftts_pkg::op_t        op;
	ftts_pkg::dp_status_t status;

	ftts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.op       (op)
	);

	// The datapath keeps B(tick_count) and B(tick_count+1) with their
	// remainders mod rate, so each fired tick is one add and one compare.
	ftts_dp #(
		.FRACTION_BITS (FRACTION_BITS),
		.TICK_BITS     (TICK_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.status         (status),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.frame_dur      (frame_dur),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.kind           (kind),
		.tick_index     (tick_index),
		.steps_run      (steps_run),
		.was_clamped    (was_clamped),
		.blend_fraction (blend_fraction),
		.frame_number   (frame_number),
		.last           (last)
	);

endmodule

// File: tb/sv/tb_fixed_timestep_tick_scheduler.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Fixed-timestep tick scheduler testbench
// Feeds frame durations through the valid/stall input and checks every tick
// and summary item against a cycle-free predictor of the accumulator. Runs a
// directed pass over the register extremes, then random phases with fixed or random
// settings, random idle on both sides bar a calm phase, one long receiver hold-off.
// -----------------------------------------------------------------------------

localparam int TICK_W = 36;
localparam int FRAC_W = 16;

typedef struct packed {
	logic                                kind;
	logic [TICK_W-1:0]                   tick_index;
	logic [ftts_pkg::STEP_W-1:0]         steps_run;
	logic                                was_clamped;
	logic [FRAC_W-1:0]                   blend_fraction;
	logic [ftts_pkg::FRAME_W-1:0]        frame_number;
	logic                                last;
} sched_item_t;

class tick_scoreboard;
	logic [ftts_pkg::RATE_W-1:0]    rate_hz;
	logic [ftts_pkg::DT_W-1:0]      frame_cap_ns;
	logic [ftts_pkg::STEP_W-1:0]    step_cap;
	logic [ftts_pkg::ELAPSED_W-1:0] elapsed_acc;
	logic [TICK_W-1:0]              tick_cnt;
	logic [ftts_pkg::FRAME_W-1:0]   frame_cnt;
	sched_item_t                    due_items[$];
	int                             mismatches;

	function new();
		rate_hz      = ftts_pkg::TICK_RATE_RST;
		frame_cap_ns = ftts_pkg::MAX_FRAME_RST;
		step_cap     = ftts_pkg::MAX_STEPS_RST;
		elapsed_acc  = '0;
		tick_cnt     = '0;
		frame_cnt    = '0;
		mismatches   = 0;
	endfunction

	function void set_reg(logic [ftts_pkg::CFG_IDX_W-1:0] idx,
			logic [ftts_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			ftts_pkg::REG_TICK_RATE: rate_hz = val[ftts_pkg::RATE_W-1:0];
			ftts_pkg::REG_MAX_FRAME: frame_cap_ns = val[ftts_pkg::DT_W-1:0];
			ftts_pkg::REG_MAX_STEPS: step_cap = val[ftts_pkg::STEP_W-1:0];
			default: ;
		endcase
	endfunction

	// floor(t * 1e9 / rate) at full width; bits 64 and up mean out of reach
	function logic [127:0] tick_edge(logic [TICK_W-1:0] t);
		logic [127:0] den;
		den = (rate_hz == '0) ? 128'd1 : 128'(rate_hz);
		return (128'(t) * 128'(ftts_pkg::NS_PER_SEC)) / den;
	endfunction

	function logic [FRAC_W-1:0] blend_now();
		logic [TICK_W-1:0] nxt;
		logic [127:0]      lo;
		logic [127:0]      hi;
		logic [63:0]       span;
		logic [63:0]       into;
		logic [63:0]       scaled;
		nxt = tick_cnt + 1'b1;
		lo  = tick_edge(tick_cnt);
		hi  = tick_edge(nxt);
		if (lo[127:64] != '0 || elapsed_acc < lo[63:0])
			return '0;
		if (hi[127:64] == '0 && hi[63:0] <= lo[63:0])
			return '0;
		span = hi[63:0] - lo[63:0];
		into = elapsed_acc - lo[63:0];
		// backlog left by the step cap: pin just below the next tick
		if (into >= span)
			into = span - 64'd1;
		scaled = into << FRAC_W;
		return FRAC_W'(scaled / span);
	endfunction

	function void note_frame(logic [ftts_pkg::DT_W-1:0] dt);
		logic [ftts_pkg::DT_W-1:0]   used;
		logic                        clamped;
		logic [ftts_pkg::STEP_W-1:0] fired;
		logic [TICK_W-1:0]           nxt;
		logic [127:0]                bnd;
		sched_item_t                 item;
		clamped     = dt > frame_cap_ns;
		used        = clamped ? frame_cap_ns : dt;
		elapsed_acc = elapsed_acc + 64'(used);
		fired       = '0;
		while (fired < step_cap) begin
			nxt = tick_cnt + 1'b1;
			bnd = tick_edge(nxt);
			if (bnd[127:64] != '0 || bnd[63:0] > elapsed_acc)
				break;
			item              = '0;
			item.kind         = ftts_pkg::KIND_TICK;
			item.tick_index   = tick_cnt;
			item.frame_number = frame_cnt;
			due_items.push_back(item);
			tick_cnt = nxt;
			fired    = fired + 1'b1;
		end
		item                = '0;
		item.kind           = ftts_pkg::KIND_SUMMARY;
		item.tick_index     = tick_cnt;
		item.steps_run      = fired;
		item.was_clamped    = clamped;
		item.blend_fraction = blend_now();
		item.frame_number   = frame_cnt;
		item.last           = 1'b1;
		due_items.push_back(item);
		frame_cnt = frame_cnt + 1'b1;
	endfunction

	function void check_result(sched_item_t got);
		sched_item_t want;
		if (due_items.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected item: kind=%0d tick=%0d frame=%0d last=%0d",
					got.kind, got.tick_index, got.frame_number, got.last);
			return;
		end
		want = due_items.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch exp: kind=%0d tick=%0d steps=%0d clamp=%0d blend=%0d frame=%0d last=%0d",
					want.kind, want.tick_index, want.steps_run, want.was_clamped,
					want.blend_fraction, want.frame_number, want.last);
				$display("         got: kind=%0d tick=%0d steps=%0d clamp=%0d blend=%0d frame=%0d last=%0d",
					got.kind, got.tick_index, got.steps_run, got.was_clamped,
					got.blend_fraction, got.frame_number, got.last);
			end
		end
	endfunction

	function int pending();
		return due_items.size();
	endfunction
endclass

module tb_fixed_timestep_tick_scheduler;

	localparam int    CLK_HALF_NS    = 10;
	localparam int    SETTLE_CYCLES  = 8;	// block is idle once the summary is out
	localparam int    RX_HOLD_CYCLES = 400;	// long enough to back up the input side
	localparam int    PHASES         = 7;
	localparam int    PHASE_FRAMES   = 50;	// 7 x 50 random frames
	// worst case: 63 ticks per frame, each waiting out a full stall,
	// over ~370 frames, taken about four times over
	localparam longint TIMEOUT_NS    = 64'd40_000_000;
	localparam int    RATE_BITS      = ftts_pkg::RATE_W;
	localparam int    STEP_BITS      = ftts_pkg::STEP_W;

	// index 3 decodes to no register
	localparam logic [ftts_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_wr_en;
	logic [ftts_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [ftts_pkg::CFG_DATA_W-1:0]    cfg_data;
	logic                               in_valid;
	logic                               in_stall;
	logic [ftts_pkg::DT_W-1:0]          frame_dur;
	logic                               out_valid;
	logic                               out_stall;
	logic                               kind;
	logic [TICK_W-1:0]                  tick_index;
	logic [ftts_pkg::STEP_W-1:0]        steps_run;
	logic                               was_clamped;
	logic [FRAC_W-1:0]                  blend_fraction;
	logic [ftts_pkg::FRAME_W-1:0]       frame_number;
	logic                               last;

	tick_scoreboard sb;
	bit             calm    = 1'b0;	// phase with no idling on either side
	int             rx_hold = 0;		// pending long hold-off for the receiver

	fixed_timestep_tick_scheduler #(
		.FRACTION_BITS (FRAC_W),
		.TICK_BITS     (TICK_W)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.frame_dur      (frame_dur),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.tick_index     (tick_index),
		.steps_run      (steps_run),
		.was_clamped    (was_clamped),
		.blend_fraction (blend_fraction),
		.frame_number   (frame_number),
		.last           (last)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Per-item idle draw; at least a third of the items go through with no wait at all.
	function automatic int idle_cycles();
		if (calm || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	// Offer one frame, hold it until taken, then log it with the predictor.
	// in_valid stays high across back-to-back items (no drop and re-raise).
	task automatic offer_frame(input logic [ftts_pkg::DT_W-1:0] dt);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		frame_dur <= dt;
		do @(posedge clk); while (!(in_valid && !in_stall));
		sb.note_frame(dt);
	endtask

	// Leaves cfg_wr_en high; the caller drops it once the batch is done.
	task automatic cfg_write(input logic [ftts_pkg::CFG_IDX_W-1:0] idx,
			input logic [ftts_pkg::CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	// Bits above the narrow registers are filled with noise; they must be dropped.
	task automatic set_mode(input logic [ftts_pkg::RATE_W-1:0] rate,
			input logic [ftts_pkg::DT_W-1:0] cap,
			input logic [ftts_pkg::STEP_W-1:0] steps, input bit poke_spare);
		logic [ftts_pkg::CFG_DATA_W-1:0] junk;
		junk = $urandom;
		cfg_write(ftts_pkg::REG_TICK_RATE,
			{junk[ftts_pkg::CFG_DATA_W-1:ftts_pkg::RATE_W], rate});
		cfg_write(ftts_pkg::REG_MAX_FRAME, cap);
		cfg_write(ftts_pkg::REG_MAX_STEPS,
			{junk[ftts_pkg::CFG_DATA_W-1:ftts_pkg::STEP_W], steps});
		if (poke_spare)
			cfg_write(REG_SPARE, $urandom);
		cfg_wr_en <= 1'b0;
	endtask

	// Wait for every expected item, then let the block fall idle.
	task automatic settle();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Output side: per-item stall draw, plus the long hold-off on request.
	initial begin
		int k;
		forever begin
			if (rx_hold > 0) begin
				out_stall <= 1'b1;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			k = idle_cycles();
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Values read right after the edge are the ones the handshake saw.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(sched_item_t'{kind, tick_index, steps_run, was_clamped,
				blend_fraction, frame_number, last});
	end

	initial begin
		logic [ftts_pkg::RATE_W-1:0]  rate;
		logic [ftts_pkg::DT_W-1:0]    cap;
		logic [ftts_pkg::STEP_W-1:0]  steps;
		logic [ftts_pkg::DT_W-1:0]    period;
		logic [ftts_pkg::DT_W-1:0]    dt;

		sb          = new();
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_index   <= ftts_pkg::REG_TICK_RATE;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		frame_dur   <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: reset settings (60 Hz, 250 ms cap, 15 steps) ---
		offer_frame(32'd0);
		offer_frame(32'd16666666);	// lands exactly on the first boundary
		offer_frame(32'd1);
		offer_frame(32'd16666667);
		offer_frame(32'd250000000);	// at the cap, not clamped
		offer_frame(32'd250000001);	// one over, clamped
		offer_frame(32'hFFFF_FFFF);	// clamped; fires a full step cap of ticks
		in_valid <= 1'b0;
		settle();

		// zero rate behaves as 1 Hz; boundary now far past elapsed time
		set_mode('0, 32'hFFFF_FFFF, 6'd63, 1'b1);
		offer_frame(32'hFFFF_FFFF);
		offer_frame(32'd0);
		offer_frame(32'd999999999);
		offer_frame(32'd1);
		in_valid <= 1'b0;
		settle();

		// zero frame cap clamps everything but zero; zero step cap fires nothing
		set_mode(10'd1000, 32'd0, 6'd0, 1'b0);
		offer_frame(32'hFFFF_FFFF);
		offer_frame(32'd0);
		offer_frame(32'd5);
		in_valid <= 1'b0;
		settle();

		// top rate with full step cap: long tick bursts
		set_mode(10'd1023, 32'hFFFF_FFFF, 6'd63, 1'b1);
		offer_frame(32'hFFFF_FFFF);
		offer_frame(32'h8000_0000);
		offer_frame(32'd12345);
		in_valid <= 1'b0;
		settle();

		// single step per frame at 1 Hz
		set_mode(10'd1, 32'd1000000000, 6'd1, 1'b0);
		offer_frame(32'hFFFF_FFFF);
		offer_frame(32'd1000000000);
		in_valid <= 1'b0;
		settle();

		// --- random phases ---
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					rate  = ftts_pkg::TICK_RATE_RST;
					cap   = ftts_pkg::MAX_FRAME_RST;
					steps = ftts_pkg::MAX_STEPS_RST;
				end
				2: begin
					rate  = 10'd1023;
					cap   = 32'hFFFF_FFFF;
					steps = 6'd63;
				end
				4: begin
					rate  = 10'd1;
					cap   = 32'hFFFF_FFFF;
					steps = 6'd63;
				end
				default: begin
					case ($urandom_range(0, 4))
						0: rate = '0;
						1: rate = 10'd1;
						2: rate = 10'd1000;
						3: rate = 10'd1023;
						default: rate = RATE_BITS'($urandom_range(1, 1023));
					endcase
					case ($urandom_range(0, 3))
						0: cap = '0;
						1: cap = 32'hFFFF_FFFF;
						2: cap = ftts_pkg::MAX_FRAME_RST;
						default: cap = $urandom;
					endcase
					case ($urandom_range(0, 3))
						0: steps = '0;
						1: steps = 6'd1;
						2: steps = 6'd63;
						default: steps = STEP_BITS'($urandom_range(1, 63));
					endcase
				end
			endcase
			set_mode(rate, cap, steps, $urandom_range(0, 3) == 0);
			calm = (p == 3);
			// receiver sits out a long stretch while frames keep coming
			if (p == 1)
				rx_hold = RX_HOLD_CYCLES;

			period = ftts_pkg::NS_PER_SEC /
				((sb.rate_hz == '0) ? 32'd1 : 32'(sb.rate_hz));
			for (int i = 0; i < PHASE_FRAMES; i++) begin
				case ($urandom_range(0, 7))
					0: dt = '0;
					1: dt = period + $urandom_range(0, 2) - 1;	// around one tick
					2: dt = $urandom_range(0, period);				// part of a tick
					3: dt = period * $urandom_range(2, 5);
					4: dt = $urandom;
					5: dt = sb.frame_cap_ns + $urandom_range(0, 2) - 1;	// around the clamp
					6: dt = 32'hFFFF_FFFF;
					default: dt = $urandom_range(0, 1000);
				endcase
				offer_frame(dt);
			end
			in_valid <= 1'b0;
			settle();
		end

		calm = 1'b0;
		if (sb.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+src
src/ftts_pkg.sv
src/ftts_ctrl.sv
src/ftts_dp.sv
src/fixed_timestep_tick_scheduler.sv
tb/sv/tb_fixed_timestep_tick_scheduler.sv
